// File: rtl/utf8_decode_script_font_router_assert.svh
// Assertion macros shared by the router RTL.
`ifndef UTF8_DECODE_SCRIPT_FONT_ROUTER_ASSERT_SVH
`define UTF8_DECODE_SCRIPT_FONT_ROUTER_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define U8R_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define U8R_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/u8r_pkg.sv
// Types, constants and the font routing function of the UTF-8 font router.
`default_nettype none

package u8r_pkg;

    localparam int CP_W      = 21;
    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 3;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = 2;

    localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;

    // Script ranges used for routing.
    localparam logic [CP_W-1:0] KANA_LO   = 21'h003040;
    localparam logic [CP_W-1:0] KANA_HI   = 21'h0030FF;
    localparam logic [CP_W-1:0] KANA_X_LO = 21'h0031F0;
    localparam logic [CP_W-1:0] KANA_X_HI = 21'h0031FF;
    localparam logic [CP_W-1:0] HANG_LO   = 21'h00AC00;
    localparam logic [CP_W-1:0] HANG_HI   = 21'h00D7AF;
    localparam logic [CP_W-1:0] JAMO_LO   = 21'h001100;
    localparam logic [CP_W-1:0] JAMO_HI   = 21'h0011FF;
    localparam logic [CP_W-1:0] CJAMO_LO  = 21'h003130;
    localparam logic [CP_W-1:0] CJAMO_HI  = 21'h00318F;
    localparam logic [CP_W-1:0] IDEO_LO   = 21'h004E00;
    localparam logic [CP_W-1:0] IDEO_HI   = 21'h009FFF;
    localparam logic [CP_W-1:0] IDEO_A_LO = 21'h003400;
    localparam logic [CP_W-1:0] IDEO_A_HI = 21'h004DBF;
    localparam logic [CP_W-1:0] IDEO_C_LO = 21'h00F900;
    localparam logic [CP_W-1:0] IDEO_C_HI = 21'h00FAFF;

    typedef enum logic [1:0] {
        FONT_JA      = 2'd0,
        FONT_CN      = 2'd1,
        FONT_KR      = 2'd2,
        FONT_BUILTIN = 2'd3
    } t_font;

    typedef enum logic [1:0] {
        CFG_EN_JA = 2'd0,
        CFG_EN_CN = 2'd1,
        CFG_EN_KR = 2'd2
    } t_cfg_idx;

    // Bit 0 Japanese, bit 1 Chinese, bit 2 Korean.
    typedef struct packed {
        logic [2:0] on;
        logic [2:0] has;
    } t_font_cfg;

    // One decoded transaction's worth of work for the back end.
    typedef struct packed {
        logic [1:0]         flush_cnt;
        logic               has_cp;
        logic [CP_W-1:0]    cp;
        logic [COUNT_W-1:0] n;
        logic               close;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    function automatic t_font default_font(input t_font_cfg fc);
        t_font f;
        priority if (fc.on[0])  f = FONT_JA;
        else if (fc.on[1])      f = FONT_CN;
        else if (fc.on[2])      f = FONT_KR;
        else if (fc.has[0])     f = FONT_JA;
        else if (fc.has[1])     f = FONT_CN;
        else if (fc.has[2])     f = FONT_KR;
        else                    f = FONT_BUILTIN;
        return f;
    endfunction

    function automatic t_font route(input logic [CP_W-1:0] cp, input t_font_cfg fc);
        logic  kana;
        logic  hangul;
        logic  ideo;
        t_font f;
        kana   = (cp >= KANA_LO && cp <= KANA_HI) || (cp >= KANA_X_LO && cp <= KANA_X_HI);
        hangul = (cp >= HANG_LO && cp <= HANG_HI) || (cp >= JAMO_LO && cp <= JAMO_HI)
              || (cp >= CJAMO_LO && cp <= CJAMO_HI);
        ideo   = (cp >= IDEO_LO && cp <= IDEO_HI) || (cp >= IDEO_A_LO && cp <= IDEO_A_HI)
              || (cp >= IDEO_C_LO && cp <= IDEO_C_HI);
        priority if (kana && fc.on[0])   f = FONT_JA;
        else if (hangul && fc.on[2])     f = FONT_KR;
        else if (ideo && fc.on[1])       f = FONT_CN;
        else if (ideo && fc.on[0])       f = FONT_JA;
        else if (ideo && fc.on[2])       f = FONT_KR;
        else                             f = default_font(fc);
        return f;
    endfunction

endpackage

`default_nettype wire

// File: rtl/u8r_byte_if.sv
// Stream interface carrying one UTF-8 byte per transaction.
`default_nettype none

interface u8r_byte_if;
    import u8r_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/u8r_char_if.sv
// Stream interface carrying one routed code point per transaction.
`default_nettype none

interface u8r_char_if;
    import u8r_pkg::*;

    logic               valid;
    logic               ready;
    logic [CP_W-1:0]    code_point;
    logic [COUNT_W-1:0] byte_count;
    logic [1:0]         font_class;
    logic               run_start;
    logic               last_result;

    modport source (output valid, output code_point, output byte_count, output font_class,
                    output run_start, output last_result, input ready);
    modport sink   (input valid, input code_point, input byte_count, input font_class,
                    input run_start, input last_result, output ready);
endinterface

`default_nettype wire

// File: rtl/u8r_cmd_queue.sv
// Small command queue between the byte decoder and the result generator.
`default_nettype none

module u8r_cmd_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire u8r_pkg::t_cmd     i_cmd,
    input  wire logic              i_pop,
    output u8r_pkg::t_q_head       o_head,
    output logic                   o_full,
    output logic [u8r_pkg::Q_AW:0] o_count
);
    import u8r_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (Q_AW+1)'(i_push) - (Q_AW+1)'(i_pop);
        end
    end

    // Head entry and status.
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];
    assign o_full       = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_count      = r_count;

endmodule

`default_nettype wire

// File: rtl/u8r_front.sv
// Front end: accepts bytes, tracks the open UTF-8 sequence and issues commands.
`default_nettype none

module u8r_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    u8r_byte_if.sink           i_in,
    input  wire logic          i_q_full,
    output logic               o_push,
    output u8r_pkg::t_cmd      o_cmd
);
    import u8r_pkg::*;

    logic [CP_W-1:0]   r_partial;
    logic [1:0]        r_remaining;
    logic [1:0]        r_held;
    logic [CP_W-1:0]   n_partial;
    logic [1:0]        n_remaining;
    logic [1:0]        n_held;
    logic [BYTE_W-1:0] b;
    logic              is_cont;
    logic              accept;
    logic              cmd_needed;
    t_cmd              cmd;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;
    assign b          = i_in.data_byte;
    assign is_cont    = (b[7:6] == 2'b10);

    // Sequence decode and command build.
    always_comb begin
        n_partial   = r_partial;
        n_remaining = r_remaining;
        n_held      = r_held;
        cmd         = '0;
        if (r_remaining != 2'd0 && is_cont) begin
            n_partial   = {r_partial[CP_W-7:0], b[5:0]};
            n_held      = r_held + 2'd1;
            n_remaining = r_remaining - 2'd1;
            if (r_remaining == 2'd1) begin
                cmd.has_cp = 1'b1;
                cmd.cp     = {r_partial[CP_W-7:0], b[5:0]};
                cmd.n      = COUNT_W'(r_held) + COUNT_W'(1);
                n_partial  = '0;
                n_held     = '0;
            end
        end else begin
            // A broken sequence flushes one replacement per held byte.
            if (r_remaining != 2'd0) begin
                cmd.flush_cnt = r_held;
            end
            n_partial   = '0;
            n_held      = '0;
            n_remaining = '0;
            priority if (b == '0) begin
                cmd.close = 1'b1;
            end else if (!b[7]) begin
                cmd.has_cp = 1'b1;
                cmd.cp     = CP_W'(b);
                cmd.n      = COUNT_W'(1);
            end else if (b[7:5] == 3'b110) begin
                n_partial   = CP_W'(b[4:0]);
                n_remaining = 2'd1;
                n_held      = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                n_partial   = CP_W'(b[3:0]);
                n_remaining = 2'd2;
                n_held      = 2'd1;
            end else if (b[7:3] == 5'b11110) begin
                n_partial   = CP_W'(b[2:0]);
                n_remaining = 2'd3;
                n_held      = 2'd1;
            end else begin
                cmd.has_cp = 1'b1;
                cmd.cp     = REPLACEMENT;
                cmd.n      = COUNT_W'(1);
            end
        end
        cmd_needed = cmd.has_cp || cmd.close || (cmd.flush_cnt != 2'd0);
    end

    // Sequence state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial   <= '0;
            r_remaining <= '0;
            r_held      <= '0;
        end else if (accept) begin
            r_partial   <= n_partial;
            r_remaining <= n_remaining;
            r_held      <= n_held;
        end
    end

    assign o_push = accept && cmd_needed;
    assign o_cmd  = cmd;

endmodule

`default_nettype wire

// File: rtl/u8r_back.sv
// Back end: expands commands into results, routes fonts and tracks runs.
`default_nettype none

module u8r_back #(
    parameter int RUN_BYTES = 96
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire u8r_pkg::t_q_head   i_head,
    input  wire u8r_pkg::t_font_cfg i_font_cfg,
    output logic                    o_pop,
    u8r_char_if.source              o_out
);
    import u8r_pkg::*;

    localparam int            RL_W      = $clog2(RUN_BYTES);
    localparam logic [RL_W:0] RUN_LIMIT = (RL_W+1)'(RUN_BYTES);

    logic [1:0]         r_done;
    logic               r_valid;
    logic [CP_W-1:0]    r_cp;
    logic [COUNT_W-1:0] r_n;
    t_font              r_font;
    logic               r_start;
    logic               r_last;
    t_font              r_cur_font;
    logic               r_font_valid;
    logic [RL_W-1:0]    r_run_len;

    t_cmd               cmd;
    logic [1:0]         flush_rem;
    logic               use_flush;
    logic               emit_req;
    logic               load;
    logic               emit;
    logic               final_piece;
    logic [CP_W-1:0]    cp_sel;
    logic [COUNT_W-1:0] n_sel;
    t_font              font_sel;
    logic [RL_W:0]      run_sum;
    logic               start;

    // Pick the next result of the head command.
    always_comb begin
        cmd         = i_head.cmd;
        flush_rem   = cmd.flush_cnt - r_done;
        use_flush   = (flush_rem != 2'd0);
        emit_req    = i_head.valid && (use_flush || cmd.has_cp);
        load        = !r_valid || o_out.ready;
        emit        = emit_req && load;
        final_piece = use_flush ? (flush_rem == 2'd1 && !cmd.has_cp) : 1'b1;
        o_pop       = (emit && final_piece) || (i_head.valid && !emit_req);
        cp_sel      = use_flush ? REPLACEMENT : cmd.cp;
        n_sel       = use_flush ? COUNT_W'(1) : cmd.n;
    end

    // Font routing and run boundary decision.
    always_comb begin
        font_sel = route(cp_sel, i_font_cfg);
        run_sum  = (RL_W+1)'(r_run_len) + (RL_W+1)'(n_sel) + (RL_W+1)'(1);
        start    = !r_font_valid || (font_sel != r_cur_font) || (run_sum > RUN_LIMIT);
    end

    // Control state: flush progress, output valid and the open run.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done       <= '0;
            r_valid      <= 1'b0;
            r_cur_font   <= FONT_JA;
            r_font_valid <= 1'b0;
            r_run_len    <= '0;
        end else begin
            if (o_pop) begin
                r_done <= '0;
            end else if (emit && use_flush) begin
                r_done <= r_done + 2'd1;
            end
            if (emit) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
            if (o_pop && cmd.close) begin
                r_font_valid <= 1'b0;
                r_run_len    <= '0;
            end else if (emit) begin
                r_cur_font   <= font_sel;
                r_font_valid <= 1'b1;
                r_run_len    <= start ? RL_W'(n_sel) : r_run_len + RL_W'(n_sel);
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_cp    <= cp_sel;
            r_n     <= n_sel;
            r_font  <= font_sel;
            r_start <= start;
            r_last  <= final_piece;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.code_point  = r_cp;
    assign o_out.byte_count  = r_n;
    assign o_out.font_class  = r_font;
    assign o_out.run_start   = r_start;
    assign o_out.last_result = r_last;

endmodule

`default_nettype wire

// File: rtl/utf8_decode_script_font_router.sv
// Top level of the UTF-8 decoder with script-based font routing.
//
//  Channel   Dir  Carries                                           Handshake
//  i_in      in   data_byte                                         valid/ready
//  o_out     out  code_point, byte_count, font_class, run_start,    valid/ready
//                 last_result
//  i_cfg_*   in   enable_japanese/chinese/korean by index           write enable
//
// One byte is accepted per cycle while the four-entry command queue has room.
// The result generator produces one result per cycle unless the output stalls; a broken
// sequence flushes one replacement per held byte, then any result of the breaking byte
// (up to four in all), and a terminator that only closes the run is popped with no output.
// Reset is synchronous and active low; the output register lets a new result
// load in the cycle the previous one is taken, and each side stalls on its own.
`default_nettype none

module utf8_decode_script_font_router #(
    parameter int RUN_BYTES    = 96,
    parameter int HAS_JAPANESE = 1,
    parameter int HAS_CHINESE  = 1,
    parameter int HAS_KOREAN   = 1
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    u8r_byte_if.sink         i_in,
    u8r_char_if.source       o_out,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic        i_cfg_wdata
);
    import u8r_pkg::*;

`include "utf8_decode_script_font_router_assert.svh"

    localparam logic [2:0] HAS_MASK = {HAS_KOREAN != 0, HAS_CHINESE != 0, HAS_JAPANESE != 0};

    logic          r_en_ja;
    logic          r_en_cn;
    logic          r_en_kr;
    t_font_cfg     font_cfg;
    logic          push;
    logic          pop;
    logic          q_full;
    logic [Q_AW:0] q_count;
    t_cmd          push_cmd;
    t_q_head       q_head;
    logic          count_ok;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en_ja <= 1'b1;
            r_en_cn <= 1'b1;
            r_en_kr <= 1'b1;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_EN_JA: r_en_ja <= i_cfg_wdata;
                CFG_EN_CN: r_en_cn <= i_cfg_wdata;
                CFG_EN_KR: r_en_kr <= i_cfg_wdata;
                default:   ;
            endcase
        end
    end

    // A font is usable only when it is both built in and enabled.
    assign font_cfg.on  = {r_en_kr, r_en_cn, r_en_ja} & HAS_MASK;
    assign font_cfg.has = HAS_MASK;

    u8r_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    u8r_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_count (q_count)
    );

    u8r_back #(
        .RUN_BYTES (RUN_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (q_head),
        .i_font_cfg (font_cfg),
        .o_pop      (pop),
        .o_out      (o_out)
    );

    // A result always reports between one and four consumed bytes.
    assign count_ok = (o_out.byte_count != 3'd0) && (o_out.byte_count <= 3'd4);

    // The queue never overflows or underflows.
    `U8R_ASSERT_IMPLIES(a_no_overflow, push && !pop, q_count != (Q_AW+1)'(Q_DEPTH), "queue overflow")
    `U8R_ASSERT_IMPLIES(a_no_underflow, pop, q_count != '0, "queue underflow")
    `U8R_ASSERT_IMPLIES(a_count_range, o_out.valid, count_ok, "bad byte count")

endmodule

`default_nettype wire

// File: tb/u8r_route_check.sv
// Monitor that predicts routed code points from accepted bytes and compares the results.

module u8r_route_check #(
    parameter int RUN_BYTES    = 96,
    parameter int HAS_JAPANESE = 1,
    parameter int HAS_CHINESE  = 1,
    parameter int HAS_KOREAN   = 1
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    u8r_byte_if             i_bytes,
    u8r_char_if             i_chars,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [1:0] i_cfg_addr,
    input  wire logic       i_cfg_wdata,
    output int              o_mismatches,
    output int              o_outstanding
);
    import u8r_pkg::*;

    typedef struct packed {
        logic [CP_W-1:0]    cp;
        logic [COUNT_W-1:0] n;
        t_font              font;
        logic               start;
        logic               last;
    } t_glyph;

    // Expected code points, oldest first.
    t_glyph glyph_q[$];

    // Runtime font enables as last written.
    logic en_ja;
    logic en_cn;
    logic en_kr;

    // Decoder state: gathered bits, continuations still due and bytes held.
    logic [CP_W-1:0] acc;
    logic [1:0]      need;
    logic [2:0]      held;

    // Open same-font run.
    t_font run_font;
    logic  run_open;
    int    run_len;

    task automatic log_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        o_mismatches++;
    endtask

    // Pick the font class for a code point from its script and the enables.
    function automatic t_font choose_font(input logic [CP_W-1:0] cp);
        logic  ja_ok;
        logic  cn_ok;
        logic  kr_ok;
        logic  kana;
        logic  hangul;
        logic  hanzi;
        t_font f;
        ja_ok  = (HAS_JAPANESE != 0) && en_ja;
        cn_ok  = (HAS_CHINESE != 0) && en_cn;
        kr_ok  = (HAS_KOREAN != 0) && en_kr;
        kana   = (cp >= 21'h3040 && cp <= 21'h30FF) || (cp >= 21'h31F0 && cp <= 21'h31FF);
        hangul = (cp >= 21'hAC00 && cp <= 21'hD7AF) || (cp >= 21'h1100 && cp <= 21'h11FF)
              || (cp >= 21'h3130 && cp <= 21'h318F);
        hanzi  = (cp >= 21'h4E00 && cp <= 21'h9FFF) || (cp >= 21'h3400 && cp <= 21'h4DBF)
              || (cp >= 21'hF900 && cp <= 21'hFAFF);
        if (kana && ja_ok) f = FONT_JA;
        else if (hangul && kr_ok) f = FONT_KR;
        else if (hanzi && cn_ok) f = FONT_CN;
        else if (hanzi && ja_ok) f = FONT_JA;
        else if (hanzi && kr_ok) f = FONT_KR;
        else if (ja_ok) f = FONT_JA;
        else if (cn_ok) f = FONT_CN;
        else if (kr_ok) f = FONT_KR;
        else if (HAS_JAPANESE != 0) f = FONT_JA;
        else if (HAS_CHINESE != 0) f = FONT_CN;
        else if (HAS_KOREAN != 0) f = FONT_KR;
        else f = FONT_BUILTIN;
        return f;
    endfunction

    // Queue one expected code point and track the run it lands in.
    task automatic credit_glyph(input logic [CP_W-1:0] cp, input logic [COUNT_W-1:0] n);
        t_glyph g;
        g.cp    = cp;
        g.n     = n;
        g.font  = choose_font(cp);
        g.start = 1'b0;
        g.last  = 1'b0;
        // A new run opens when none is open, on a font change or when the buffer would overflow.
        if (!run_open || g.font != run_font || run_len + int'(n) + 1 > RUN_BYTES) begin
            g.start  = 1'b1;
            run_font = g.font;
            run_open = 1'b1;
            run_len  = 0;
        end
        run_len = run_len + int'(n);
        glyph_q.push_back(g);
    endtask

    // Handle a byte with no sequence open.
    task automatic fresh_byte(input logic [7:0] b);
        if (b == 8'h00) begin
            run_open = 1'b0;
            run_len  = 0;
        end else if (!b[7]) begin
            credit_glyph({13'd0, b}, 3'd1);
        end else if (b[7:5] == 3'b110) begin
            acc  = {16'd0, b[4:0]};
            need = 2'd1;
            held = 3'd1;
        end else if (b[7:4] == 4'b1110) begin
            acc  = {17'd0, b[3:0]};
            need = 2'd2;
            held = 3'd1;
        end else if (b[7:3] == 5'b11110) begin
            acc  = {18'd0, b[2:0]};
            need = 2'd3;
            held = 3'd1;
        end else begin
            credit_glyph(REPLACEMENT, 3'd1);
        end
    endtask

    // Work out every result one accepted byte causes.
    task automatic absorb_byte(input logic [7:0] b);
        int mark;
        mark = glyph_q.size();
        if (need != 2'd0) begin
            if (b[7:6] == 2'b10) begin
                acc  = {acc[CP_W-7:0], b[5:0]};
                held = held + 3'd1;
                need = need - 2'd1;
                if (need == 2'd0) begin
                    credit_glyph(acc, held);
                    acc  = '0;
                    held = 3'd0;
                end
            end else begin
                // Broken sequence: one replacement per held byte, then start over.
                for (int k = 0; k < int'(held); k++) begin
                    credit_glyph(REPLACEMENT, 3'd1);
                end
                acc  = '0;
                held = 3'd0;
                need = 2'd0;
                fresh_byte(b);
            end
        end else begin
            fresh_byte(b);
        end
        if (glyph_q.size() > mark) begin
            glyph_q[glyph_q.size() - 1].last = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        t_glyph want;
        if (!i_rst_n) begin
            glyph_q.delete();
            en_ja    = 1'b1;
            en_cn    = 1'b1;
            en_kr    = 1'b1;
            acc      = '0;
            need     = 2'd0;
            held     = 3'd0;
            run_font = FONT_JA;
            run_open = 1'b0;
            run_len  = 0;
        end else begin
            // Register writes land before any byte of the next phase.
            if (i_cfg_wr_en) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_EN_JA: en_ja = i_cfg_wdata;
                    CFG_EN_CN: en_cn = i_cfg_wdata;
                    CFG_EN_KR: en_kr = i_cfg_wdata;
                    default: ;
                endcase
            end

            // Predict first so that the queue holds everything accepted so far.
            if (i_bytes.valid && i_bytes.ready) begin
                absorb_byte(i_bytes.data_byte);
            end

            // Compare each result transaction with the oldest expectation.
            if (i_chars.valid && i_chars.ready) begin
                if (glyph_q.size() == 0) begin
                    log_mismatch($sformatf("unexpected result cp=%h", i_chars.code_point));
                end else begin
                    want = glyph_q.pop_front();
                    if (i_chars.code_point !== want.cp) begin
                        log_mismatch($sformatf("code_point %h, want %h",
                                               i_chars.code_point, want.cp));
                    end
                    if (i_chars.byte_count !== want.n) begin
                        log_mismatch($sformatf("byte_count %0d, want %0d for cp %h",
                                               i_chars.byte_count, want.n, want.cp));
                    end
                    if (i_chars.font_class !== want.font) begin
                        log_mismatch($sformatf("font_class %0d, want %0d for cp %h",
                                               i_chars.font_class, want.font, want.cp));
                    end
                    if (i_chars.run_start !== want.start) begin
                        log_mismatch($sformatf("run_start %b, want %b for cp %h",
                                               i_chars.run_start, want.start, want.cp));
                    end
                    if (i_chars.last_result !== want.last) begin
                        log_mismatch($sformatf("last_result %b, want %b for cp %h",
                                               i_chars.last_result, want.last, want.cp));
                    end
                end
            end
        end
        o_outstanding = glyph_q.size();
    end

endmodule

// File: tb/testbench.sv
// Top of the UTF-8 font router regression: stimulus, idling, pressure and the verdict.

module testbench;
    import u8r_pkg::*;

    localparam int RUN_BYTES    = 96;
    localparam int HAS_JAPANESE = 1;
    localparam int HAS_CHINESE  = 1;
    localparam int HAS_KOREAN   = 1;
    localparam int PHASES       = 6;
    localparam int PHASE_BYTES  = 72;
    localparam int DRAIN_CYCLES = 24;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_wr_en;
    logic [1:0] cfg_addr;
    logic       cfg_wdata;
    int         mismatches;
    int         outstanding;

    // Idle percentages of each side and the length of a receiver hold-off.
    int send_idle_pct;
    int recv_idle_pct;
    int stall_left;

    // Bytes of the string being sent.
    logic [7:0] stream_q[$];

    u8r_byte_if in_bus();
    u8r_char_if out_bus();

    utf8_decode_script_font_router #(
        .RUN_BYTES    (RUN_BYTES),
        .HAS_JAPANESE (HAS_JAPANESE),
        .HAS_CHINESE  (HAS_CHINESE),
        .HAS_KOREAN   (HAS_KOREAN)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_bus),
        .o_out       (out_bus),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    u8r_route_check #(
        .RUN_BYTES    (RUN_BYTES),
        .HAS_JAPANESE (HAS_JAPANESE),
        .HAS_CHINESE  (HAS_CHINESE),
        .HAS_KOREAN   (HAS_KOREAN)
    ) route_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_bytes       (in_bus),
        .i_chars       (out_bus),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_wdata   (cfg_wdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Receiver: random back-pressure, or a long hold-off when one is requested.
    initial begin
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                out_bus.ready <= 1'b0;
                stall_left = stall_left - 1;
            end else begin
                out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one byte, idling at random first, and return once it is taken.
    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.data_byte <= b;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Send the whole string; optionally hold off the receiver early on.
    task automatic send_stream(input logic hold_off);
        for (int k = 0; k < stream_q.size(); k++) begin
            if (hold_off && k == 5) begin
                stall_left = 60;
            end
            push_byte(stream_q[k]);
        end
        stream_q.delete();
    endtask

    // Wait until every expected result is in and the block has gone quiet.
    task automatic drain_results();
        in_bus.valid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Write the three font enables back to back; bit 0 Japanese, 1 Chinese, 2 Korean.
    task automatic load_enables(input logic [2:0] en);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_EN_JA;
        cfg_wdata <= en[0];
        @(negedge i_clk);
        cfg_addr  <= CFG_EN_CN;
        cfg_wdata <= en[1];
        @(negedge i_clk);
        cfg_addr  <= CFG_EN_KR;
        cfg_wdata <= en[2];
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Append the UTF-8 encoding of a code point, up to 21 bits.
    function automatic void put_cp(input logic [20:0] cp);
        if (cp < 21'h80) begin
            stream_q.push_back(cp[7:0]);
        end else if (cp < 21'h800) begin
            stream_q.push_back({3'b110, cp[10:6]});
            stream_q.push_back({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            stream_q.push_back({4'b1110, cp[15:12]});
            stream_q.push_back({2'b10, cp[11:6]});
            stream_q.push_back({2'b10, cp[5:0]});
        end else begin
            stream_q.push_back({5'b11110, cp[20:18]});
            stream_q.push_back({2'b10, cp[17:12]});
            stream_q.push_back({2'b10, cp[11:6]});
            stream_q.push_back({2'b10, cp[5:0]});
        end
    endfunction

    // Draw a code point from one class of content.
    function automatic logic [20:0] random_cp(input int group);
        logic [20:0] cp;
        case (group)
            0: cp = 21'($urandom_range(1, 127));
            1: cp = $urandom_range(1) ? 21'($urandom_range(21'h31F0, 21'h31FF))
                                      : 21'($urandom_range(21'h3040, 21'h30FF));
            2: case ($urandom_range(2))
                   0: cp = 21'($urandom_range(21'hAC00, 21'hD7AF));
                   1: cp = 21'($urandom_range(21'h1100, 21'h11FF));
                   default: cp = 21'($urandom_range(21'h3130, 21'h318F));
               endcase
            3: case ($urandom_range(2))
                   0: cp = 21'($urandom_range(21'h4E00, 21'h9FFF));
                   1: cp = 21'($urandom_range(21'h3400, 21'h4DBF));
                   default: cp = 21'($urandom_range(21'hF900, 21'hFAFF));
               endcase
            4: cp = 21'($urandom_range(21'h80, 21'h7FF));
            5: cp = 21'($urandom_range(21'h800, 21'hFFFF));
            6: cp = 21'($urandom_range(21'h10000, 21'h1FFFFF));
            default: begin
                // At or next to one end of a script range, U+10FFFF or the top of the 21-bit range.
                case ($urandom_range(17))
                    0: cp = KANA_LO;
                    1: cp = KANA_HI;
                    2: cp = KANA_X_LO;
                    3: cp = KANA_X_HI;
                    4: cp = HANG_LO;
                    5: cp = HANG_HI;
                    6: cp = JAMO_LO;
                    7: cp = JAMO_HI;
                    8: cp = CJAMO_LO;
                    9: cp = CJAMO_HI;
                    10: cp = IDEO_LO;
                    11: cp = IDEO_HI;
                    12: cp = IDEO_A_LO;
                    13: cp = IDEO_A_HI;
                    14: cp = IDEO_C_LO;
                    15: cp = IDEO_C_HI;
                    16: cp = 21'h10FFFF;
                    default: cp = 21'h1FFFFE;
                endcase
                cp = cp + 21'($urandom_range(2)) - 21'd1;
            end
        endcase
        return cp;
    endfunction

    // Mostly well-formed strings in one script, with some noise mixed in.
    task automatic build_stream(input int target);
        int script;
        int len;
        int mark;
        int cut;
        while (stream_q.size() < target) begin
            if ($urandom_range(99) < 15) begin
                case ($urandom_range(3))
                    0: stream_q.push_back(8'($urandom_range(255)));
                    1: begin
                        // A multi-byte sequence cut short.
                        mark = stream_q.size();
                        put_cp(random_cp($urandom_range(3, 6)));
                        cut  = $urandom_range(1, stream_q.size() - mark - 1);
                        repeat (cut) void'(stream_q.pop_back());
                    end
                    2: stream_q.push_back(8'h80 | 8'($urandom_range(63)));
                    default: stream_q.push_back(8'hF8 | 8'($urandom_range(7)));
                endcase
            end else begin
                script = $urandom_range(7);
                len    = $urandom_range(1, 40);
                repeat (len) begin
                    put_cp(random_cp($urandom_range(9) < 7 ? script : $urandom_range(7)));
                end
                if ($urandom_range(99) < 35) begin
                    stream_q.push_back(8'h00);
                end
            end
        end
        // Keep each phase at its planned length.
        while (stream_q.size() > target) void'(stream_q.pop_back());
    endtask

    // Main stimulus and verdict.
    initial begin
        logic [2:0] phase_en[PHASES];
        phase_en      = '{3'b000, 3'b010, 3'b101, 3'b001, 3'b110, 3'b011};
        i_rst_n       = 1'b0;
        in_bus.valid  = 1'b0;
        in_bus.data_byte = 8'h00;
        cfg_wr_en     = 1'b0;
        cfg_addr      = CFG_EN_JA;
        cfg_wdata     = 1'b0;
        stall_left    = 0;
        send_idle_pct = 32;
        recv_idle_pct = 87;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        load_enables(3'b111);

        // Directed: terminators, ASCII ends, bad leads, each length and script,
        // a value past U+10FFFF, a broken four-byte sequence and a flush by terminator.
        stream_q = '{8'h00, 8'h41, 8'h7F, 8'h80, 8'hFF,
                     8'hC3, 8'hA9,
                     8'hE3, 8'h81, 8'h82,
                     8'hE4, 8'hB8, 8'h80,
                     8'hEA, 8'hB0, 8'h80,
                     8'hF7, 8'hBF, 8'hBF, 8'hBF,
                     8'hF0, 8'h90, 8'h80, 8'h41,
                     8'hC3, 8'h00};
        send_stream(1'b0);

        // Random phases under changing enables and idling patterns.
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            if (p == 2) begin
                send_idle_pct = 87;
                recv_idle_pct = 32;
            end else if (p == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            load_enables(phase_en[p]);
            build_stream(PHASE_BYTES);
            send_stream(p == 4);
        end
        drain_results();

        if (mismatches == 0) begin
            $display("utf8_decode_script_font_router regression: pass");
        end else begin
            $display("utf8_decode_script_font_router regression: fail");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2000000;
        $display("utf8_decode_script_font_router regression: fail");
        $finish;
    end

endmodule

// File: utf8_decode_script_font_router.f
+incdir+rtl
rtl/u8r_pkg.sv
rtl/u8r_byte_if.sv
rtl/u8r_char_if.sv
rtl/u8r_cmd_queue.sv
rtl/u8r_front.sv
rtl/u8r_back.sv
rtl/utf8_decode_script_font_router.sv
tb/u8r_route_check.sv
tb/testbench.sv
